// File: src/rsfm_pkg.sv
// ----------------------------------------------------------------------------
// Routed saturating frame mixer package
// Shared widths, register indexes, frame and control types, and the
// saturating add used by every mixing cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsfm_pkg;

  localparam int MaxChannels = 4;
  localparam int MaskBits    = 11;
  localparam int SampleW     = 16;
  localparam int CountW      = 3;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = MaxChannels * MaskBits;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSrcMasks = 3'd0,
    CfgDstMasks = 3'd1,
    CfgSrcCount = 3'd2,
    CfgDstCount = 3'd3
  } cfg_reg_e;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [MaskBits-1:0]       mask_t;

  typedef struct packed {
    sample_t [MaxChannels-1:0] acc;
    sample_t [MaxChannels-1:0] src;
  } frame_t;

  typedef struct packed {
    mask_t [MaxChannels-1:0]  src_mask;
    mask_t [MaxChannels-1:0]  dst_mask;
    logic [MaxChannels-1:0]   src_en;
    logic [MaxChannels-1:0]   lane_en;
  } mix_ctrl_t;

  function automatic sample_t sat_add(sample_t a, sample_t b);
    logic signed [SampleW:0] sum;
    sample_t                 res;
    sum = {a[SampleW-1], a} + {b[SampleW-1], b};
    if (sum[SampleW] != sum[SampleW-1]) begin
      res = sum[SampleW] ? {1'b1, {(SampleW-1){1'b0}}} : {1'b0, {(SampleW-1){1'b1}}};
    end else begin
      res = sum[SampleW-1:0];
    end
    return res;
  endfunction

endpackage

// File: src/rsfm_cfg.sv
// ----------------------------------------------------------------------------
// Mixer configuration registers
// Holds the routing masks and channel counts and decodes them into the
// per-cell control bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsfm_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rsfm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rsfm_pkg::CfgDataW-1:0]  cfg_data_i,
  output rsfm_pkg::mix_ctrl_t            ctrl_o
);

  logic [rsfm_pkg::CfgDataW-1:0] src_masks_q, src_masks_d;
  logic [rsfm_pkg::CfgDataW-1:0] dst_masks_q, dst_masks_d;
  logic [rsfm_pkg::CountW-1:0]   src_count_q, src_count_d;
  logic [rsfm_pkg::CountW-1:0]   dst_count_q, dst_count_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    src_masks_d = src_masks_q;
    dst_masks_d = dst_masks_q;
    src_count_d = src_count_q;
    dst_count_d = dst_count_q;
    if (cfg_valid_i) begin
      case (rsfm_pkg::cfg_reg_e'(cfg_index_i))
        rsfm_pkg::CfgSrcMasks: src_masks_d = cfg_data_i;
        rsfm_pkg::CfgDstMasks: dst_masks_d = cfg_data_i;
        rsfm_pkg::CfgSrcCount: src_count_d = cfg_data_i[rsfm_pkg::CountW-1:0];
        rsfm_pkg::CfgDstCount: dst_count_d = cfg_data_i[rsfm_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_masks_q <= '0;
      dst_masks_q <= '0;
      src_count_q <= '0;
      dst_count_q <= '0;
    end else begin
      src_masks_q <= src_masks_d;
      dst_masks_q <= dst_masks_d;
      src_count_q <= src_count_d;
      dst_count_q <= dst_count_d;
    end
  end

  always_comb begin
    for (int k = 0; k < rsfm_pkg::MaxChannels; k++) begin
      ctrl_o.src_mask[k] = src_masks_q[k*rsfm_pkg::MaskBits +: rsfm_pkg::MaskBits];
      ctrl_o.dst_mask[k] = dst_masks_q[k*rsfm_pkg::MaskBits +: rsfm_pkg::MaskBits];
      ctrl_o.src_en[k]   = (src_count_q > rsfm_pkg::CountW'(k));
      ctrl_o.lane_en[k]  = (dst_count_q > rsfm_pkg::CountW'(k));
    end
  end

endmodule

// File: src/rsfm_cell.sv
// ----------------------------------------------------------------------------
// Mixer cell
// Adds one source channel into every routed destination lane with
// saturation and hands the frame to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsfm_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  rsfm_pkg::frame_t     frame_i,
  input  rsfm_pkg::sample_t    sample_i,
  input  rsfm_pkg::mask_t      src_mask_i,
  input  logic                 src_en_i,
  input  rsfm_pkg::mix_ctrl_t  ctrl_i,
  output logic                 valid_o,
  output rsfm_pkg::frame_t     frame_o
);

  logic [rsfm_pkg::MaxChannels-1:0] hit;
  rsfm_pkg::frame_t                 frame_d, frame_q;
  logic                             valid_q;

  always_comb begin
    frame_d = frame_i;
    for (int d = 0; d < rsfm_pkg::MaxChannels; d++) begin
      hit[d] = src_en_i && ctrl_i.lane_en[d] && (|(src_mask_i & ctrl_i.dst_mask[d]));
      if (hit[d]) begin
        frame_d.acc[d] = rsfm_pkg::sat_add(frame_i.acc[d], sample_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      frame_q <= frame_d;
    end
  end

  assign valid_o = valid_q;
  assign frame_o = frame_q;

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> valid_q == $past(valid_i))
    else $error("cell valid did not follow its input on advance");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !en_i |=> valid_q && $stable(frame_q))
    else $error("cell frame changed while held");

  a_no_route: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && valid_i && (hit == '0) |=> frame_q == $past(frame_i))
    else $error("unrouted frame was modified");

endmodule

// File: src/routed_saturating_frame_mixer.sv
// ----------------------------------------------------------------------------
// Routed saturating frame mixer
// An accepted input transaction passes through the registered mixing
// cells, one per source channel. Throughput: one frame per cycle; the
// chain advances as a whole and holds only while the output is stalled.
// Reset clears all configuration registers to zero and empties the chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module routed_saturating_frame_mixer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rsfm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rsfm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [15:0]             src_sample_0_i,
  input  logic signed [15:0]             src_sample_1_i,
  input  logic signed [15:0]             src_sample_2_i,
  input  logic signed [15:0]             src_sample_3_i,
  input  logic signed [15:0]             dst_sample_0_i,
  input  logic signed [15:0]             dst_sample_1_i,
  input  logic signed [15:0]             dst_sample_2_i,
  input  logic signed [15:0]             dst_sample_3_i,
  input  logic                           clear_first_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [15:0]             mixed_0_o,
  output logic signed [15:0]             mixed_1_o,
  output logic signed [15:0]             mixed_2_o,
  output logic signed [15:0]             mixed_3_o
);

  rsfm_pkg::mix_ctrl_t ctrl;
  rsfm_pkg::frame_t    frame_in;
  rsfm_pkg::frame_t    chain_frame [rsfm_pkg::MaxChannels+1];
  logic                chain_valid [rsfm_pkg::MaxChannels+1];
  logic                en;

  rsfm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctrl_o      (ctrl)
  );

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  always_comb begin
    frame_in.src[0] = src_sample_0_i;
    frame_in.src[1] = src_sample_1_i;
    frame_in.src[2] = src_sample_2_i;
    frame_in.src[3] = src_sample_3_i;
    frame_in.acc[0] = clear_first_i ? '0 : dst_sample_0_i;
    frame_in.acc[1] = clear_first_i ? '0 : dst_sample_1_i;
    frame_in.acc[2] = clear_first_i ? '0 : dst_sample_2_i;
    frame_in.acc[3] = clear_first_i ? '0 : dst_sample_3_i;
  end

  assign chain_frame[0] = frame_in;
  assign chain_valid[0] = in_valid_i;

  for (genvar k = 0; k < rsfm_pkg::MaxChannels; k++) begin : g_cell
    rsfm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .valid_i    (chain_valid[k]),
      .frame_i    (chain_frame[k]),
      .sample_i   (chain_frame[k].src[k]),
      .src_mask_i (ctrl.src_mask[k]),
      .src_en_i   (ctrl.src_en[k]),
      .ctrl_i     (ctrl),
      .valid_o    (chain_valid[k+1]),
      .frame_o    (chain_frame[k+1])
    );
  end

  assign out_valid_o = chain_valid[rsfm_pkg::MaxChannels];
  assign mixed_0_o   = chain_frame[rsfm_pkg::MaxChannels].acc[0];
  assign mixed_1_o   = chain_frame[rsfm_pkg::MaxChannels].acc[1];
  assign mixed_2_o   = chain_frame[rsfm_pkg::MaxChannels].acc[2];
  assign mixed_3_o   = chain_frame[rsfm_pkg::MaxChannels].acc[3];

endmodule
